[src/dbn_pkg.sv]
// ----------------------------------------------------------------------------
// Button debounce package
// Shared constants, phase codes and types for the debounce and press-event
// block.
// ----------------------------------------------------------------------------
package dbn_pkg;

  // History length and the masked patterns that decide press and release.
  localparam int unsigned HistBits = 16;
  localparam logic [HistBits-1:0] HistAll    = 16'hFFFF;
  localparam logic [HistBits-1:0] PatMask    = 16'hF03F;
  localparam logic [HistBits-1:0] PatPress   = 16'h003F;
  localparam logic [HistBits-1:0] PatRelease = 16'hF000;

  // Time arithmetic.
  localparam int unsigned TimeW = 32;
  localparam logic [TimeW-1:0] CooldownMs = 32'd50;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CfgActiveLevel = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLongPressMs = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDoubleWinMs = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgDoubleEn    = 2'd3;

  // Register reset values.
  localparam logic             RstActiveLevel = 1'b1;
  localparam logic [TimeW-1:0] RstLongPressMs = 32'd1000;
  localparam logic [TimeW-1:0] RstDoubleWinMs = 32'd300;
  localparam logic             RstDoubleEn    = 1'b0;

  // Double-press phase codes.
  localparam int unsigned PhaseW = 3;
  localparam logic [PhaseW-1:0] PhIdle     = 3'd0;
  localparam logic [PhaseW-1:0] PhFirst    = 3'd1;
  localparam logic [PhaseW-1:0] PhAwait    = 3'd2;
  localparam logic [PhaseW-1:0] PhDetected = 3'd3;
  localparam logic [PhaseW-1:0] PhCooldown = 3'd4;

  // Events derived from the history in one step.
  typedef struct packed {
    logic pressed;
    logic released;
    logic down;
    logic up;
    logic changed;
  } hist_ev_t;

  // One result word.
  typedef struct packed {
    logic press_event;
    logic release_event;
    logic held_down;
    logic held_up;
    logic down_changed;
    logic long_start;
    logic long_end;
    logic double_press;
  } result_t;

endpackage

[src/dbn_if.sv]
// ----------------------------------------------------------------------------
// Button debounce channel interfaces
// Valid/ready channels for pin samples and for result words.
// ----------------------------------------------------------------------------

// Pin sample channel.
interface dbn_in_if;
  logic                       valid;
  logic                       ready;
  logic                       pin_level;
  logic [dbn_pkg::TimeW-1:0]  now_ms;

  modport source (output valid, output pin_level, output now_ms, input ready);
  modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

// Result word channel.
interface dbn_out_if;
  logic valid;
  logic ready;
  logic press_event;
  logic release_event;
  logic held_down;
  logic held_up;
  logic down_changed;
  logic long_start;
  logic long_end;
  logic double_press;

  modport source (
    output valid, output press_event, output release_event, output held_down,
    output held_up, output down_changed, output long_start, output long_end,
    output double_press, input ready
  );
  modport sink (
    input valid, input press_event, input release_event, input held_down,
    input held_up, input down_changed, input long_start, input long_end,
    input double_press, output ready
  );
endinterface

[src/button_debounce_press_events_core.sv]
// ----------------------------------------------------------------------------
// Button debounce with press events
// Debounces one pin sample per word and reports press, release, long-press
// and double-press events as one result word per sample.
// ----------------------------------------------------------------------------
// Each accepted sample's result word is registered in the result queue and
// waits there until the output takes it.
// Throughput: one sample per cycle while the result queue has space; all
// event logic sits between the state registers and a two-word result
// queue, which also absorbs output stalls. Reset: asynchronous, active low;
// history reads button up, registers take their defaults and the queue empties.
module button_debounce_press_events_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  dbn_in_if.sink                       in_s,
  dbn_out_if.source                    out_s,
  input  logic                         cfg_we_i,
  input  logic [dbn_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [dbn_pkg::CfgDataW-1:0] cfg_data_i
);

  logic                      active_level_q;
  logic [dbn_pkg::TimeW-1:0] long_press_ms_q;
  logic [dbn_pkg::TimeW-1:0] window_ms_q;
  logic                      double_en_q;

  logic              step;
  logic              space;
  logic              dbl_clear;
  dbn_pkg::hist_ev_t ev;
  logic              long_start, long_end, double_hit;
  dbn_pkg::result_t  res, head;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_level_q  <= dbn_pkg::RstActiveLevel;
      long_press_ms_q <= dbn_pkg::RstLongPressMs;
      window_ms_q     <= dbn_pkg::RstDoubleWinMs;
      double_en_q     <= dbn_pkg::RstDoubleEn;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dbn_pkg::CfgActiveLevel: active_level_q  <= cfg_data_i[0];
        dbn_pkg::CfgLongPressMs: long_press_ms_q <= cfg_data_i;
        dbn_pkg::CfgDoubleWinMs: window_ms_q     <= cfg_data_i;
        dbn_pkg::CfgDoubleEn:    double_en_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign dbl_clear = cfg_we_i && (cfg_idx_i == dbn_pkg::CfgDoubleEn);

  // Input handshake.
  assign in_s.ready = space;
  assign step       = in_s.valid && space;

  dbn_hist u_hist (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .pin_level_i    (in_s.pin_level),
    .active_level_i (active_level_q),
    .ev_o           (ev)
  );

  dbn_long u_long (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .down_i          (ev.down),
    .now_ms_i        (in_s.now_ms),
    .long_press_ms_i (long_press_ms_q),
    .long_start_o    (long_start),
    .long_end_o      (long_end)
  );

  dbn_dbl u_dbl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .enable_i    (double_en_q),
    .clear_i     (dbl_clear),
    .pressed_i   (ev.pressed),
    .released_i  (ev.released),
    .now_ms_i    (in_s.now_ms),
    .window_ms_i (window_ms_q),
    .double_o    (double_hit)
  );

  // Assemble the result word.
  always_comb begin
    res.press_event   = ev.pressed;
    res.release_event = ev.released;
    res.held_down     = ev.down;
    res.held_up       = ev.up;
    res.down_changed  = ev.changed;
    res.long_start    = long_start;
    res.long_end      = long_end;
    res.double_press  = double_hit;
  end

  dbn_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .word_i  (res),
    .space_o (space),
    .valid_o (out_s.valid),
    .ready_i (out_s.ready),
    .word_o  (head)
  );

  // Output payload.
  assign out_s.press_event   = head.press_event;
  assign out_s.release_event = head.release_event;
  assign out_s.held_down     = head.held_down;
  assign out_s.held_up       = head.held_up;
  assign out_s.down_changed  = head.down_changed;
  assign out_s.long_start    = head.long_start;
  assign out_s.long_end      = head.long_end;
  assign out_s.double_press  = head.double_press;

  // Held down and held up never show together.
  a_down_up_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> !(ev.down && ev.up))
    else $error("history both all ones and all zeros");

endmodule

[src/dbn_hist.sv]
// ----------------------------------------------------------------------------
// Debounce history
// Shifts the qualified pin level into the history and matches the press and
// release patterns.
// ----------------------------------------------------------------------------
module dbn_hist (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic               pin_level_i,
  input  logic               active_level_i,
  output dbn_pkg::hist_ev_t  ev_o
);

  logic [dbn_pkg::HistBits-1:0] hist_q, hist_d;
  logic [dbn_pkg::HistBits-1:0] shifted, after_press;
  logic                         prev_down;

  // Shift, then test press first and release on what the press test left.
  always_comb begin
    shifted     = {hist_q[dbn_pkg::HistBits-2:0], pin_level_i == active_level_i};
    prev_down   = (shifted == dbn_pkg::HistAll);
    ev_o.pressed = ((shifted & dbn_pkg::PatMask) == dbn_pkg::PatPress);
    after_press = ev_o.pressed ? dbn_pkg::HistAll : shifted;
    ev_o.released = ((after_press & dbn_pkg::PatMask) == dbn_pkg::PatRelease);
    hist_d      = ev_o.released ? '0 : after_press;
    ev_o.down   = (hist_d == dbn_pkg::HistAll);
    ev_o.up     = (hist_d == '0);
    ev_o.changed = (ev_o.down != prev_down);
  end

  // History register; reset means button up for either polarity.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else if (step_i) begin
      hist_q <= hist_d;
    end
  end

endmodule

[src/dbn_long.sv]
// ----------------------------------------------------------------------------
// Long-press detector
// Times how long the button stays down and pulses at the threshold and at
// the release that follows it.
// ----------------------------------------------------------------------------
module dbn_long (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic                      down_i,
  input  logic [dbn_pkg::TimeW-1:0] now_ms_i,
  input  logic [dbn_pkg::TimeW-1:0] long_press_ms_i,
  output logic                      long_start_o,
  output logic                      long_end_o
);

  logic                      was_down_q, was_down_d;
  logic                      long_seen_q, long_seen_d;
  logic [dbn_pkg::TimeW-1:0] start_q, start_d;
  logic [dbn_pkg::TimeW-1:0] held;

  // Held time wraps modulo 2^32.
  assign held = now_ms_i - start_q;

  always_comb begin
    was_down_d   = was_down_q;
    long_seen_d  = long_seen_q;
    start_d      = start_q;
    long_start_o = 1'b0;
    long_end_o   = 1'b0;
    if (down_i) begin
      if (!was_down_q) begin
        was_down_d  = 1'b1;
        start_d     = now_ms_i;
        long_seen_d = 1'b0;
      end else if (!long_seen_q && (held >= long_press_ms_i)) begin
        long_seen_d  = 1'b1;
        long_start_o = 1'b1;
      end
    end else if (was_down_q) begin
      was_down_d = 1'b0;
      long_end_o = long_seen_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_down_q  <= 1'b0;
      long_seen_q <= 1'b0;
      start_q     <= '0;
    end else if (step_i) begin
      was_down_q  <= was_down_d;
      long_seen_q <= long_seen_d;
      start_q     <= start_d;
    end
  end

endmodule

[src/dbn_dbl.sv]
// ----------------------------------------------------------------------------
// Double-press detector
// Five-phase machine that reports a second press inside the window and then
// waits out a fixed cooldown.
// ----------------------------------------------------------------------------
module dbn_dbl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic                      enable_i,
  input  logic                      clear_i,
  input  logic                      pressed_i,
  input  logic                      released_i,
  input  logic [dbn_pkg::TimeW-1:0] now_ms_i,
  input  logic [dbn_pkg::TimeW-1:0] window_ms_i,
  output logic                      double_o
);

  logic [dbn_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [dbn_pkg::TimeW-1:0]  first_q, first_d;
  logic [dbn_pkg::TimeW-1:0]  since_first;
  logic                       hit;

  assign since_first = now_ms_i - first_q;

  // Phase transitions for one step.
  always_comb begin
    phase_d = phase_q;
    first_d = first_q;
    hit     = 1'b0;
    case (phase_q)
      dbn_pkg::PhIdle: begin
        if (pressed_i) begin
          phase_d = dbn_pkg::PhFirst;
          first_d = now_ms_i;
        end
      end
      dbn_pkg::PhFirst: begin
        if (released_i) phase_d = dbn_pkg::PhAwait;
      end
      dbn_pkg::PhAwait: begin
        if (pressed_i) begin
          if (since_first < window_ms_i) begin
            phase_d = dbn_pkg::PhDetected;
            hit     = 1'b1;
          end else begin
            phase_d = dbn_pkg::PhFirst;
            first_d = now_ms_i;
          end
        end else if (since_first >= window_ms_i) begin
          phase_d = dbn_pkg::PhIdle;
        end
      end
      dbn_pkg::PhDetected: begin
        if (released_i) phase_d = dbn_pkg::PhCooldown;
      end
      dbn_pkg::PhCooldown: begin
        if (since_first >= dbn_pkg::CooldownMs) phase_d = dbn_pkg::PhIdle;
      end
      default: phase_d = dbn_pkg::PhIdle;
    endcase
  end

  // The machine holds its phase while disabled; an enable write returns it to idle.
  assign double_o = enable_i && hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dbn_pkg::PhIdle;
      first_q <= '0;
    end else if (clear_i) begin
      phase_q <= dbn_pkg::PhIdle;
    end else if (step_i && enable_i) begin
      phase_q <= phase_d;
      first_q <= first_d;
    end
  end

  // A double press comes only from the awaiting phase on a fresh press.
  a_hit_from_await: assert property (@(posedge clk_i) disable iff (!rst_ni)
    double_o |-> (phase_q == dbn_pkg::PhAwait) && pressed_i)
    else $error("double press outside the awaiting phase");

  // After a double press the machine sits in the detected phase.
  a_hit_next_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (double_o && step_i && !clear_i) |=> (phase_q == dbn_pkg::PhDetected))
    else $error("double press did not move to the detected phase");

endmodule

[src/dbn_outq.sv]
// ----------------------------------------------------------------------------
// Result queue
// Two-word output buffer so that a new sample is taken while a result still
// waits at the output.
// ----------------------------------------------------------------------------
module dbn_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dbn_pkg::result_t  word_i,
  output logic              space_o,
  output logic              valid_o,
  input  logic              ready_i,
  output dbn_pkg::result_t  word_o
);

  logic [1:0]        cnt_q, cnt_d;
  dbn_pkg::result_t  head_q, head_d, tail_q, tail_d;
  logic              pop;

  assign space_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign word_o  = head_q;
  assign pop     = valid_o && ready_i;

  // Head and tail update for push, pop or both.
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (pop) begin
      head_d = tail_q;
      cnt_d  = cnt_d - 2'd1;
    end
    if (push_i) begin
      if (cnt_d == 2'd0) begin
        head_d = word_i;
      end else begin
        tail_d = word_i;
      end
      cnt_d = cnt_d + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result queue count out of range");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
    else $error("push without pop did not grow the queue");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_i) |=> (cnt_q == $past(cnt_q) - 2'd1))
    else $error("pop without push did not shrink the queue");

endmodule

[tb/tb_button_debounce_press_events_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce press-event testbench
// Feeds pin samples with millisecond timestamps into the debounce core and
// checks every result word against an in-bench model of the history,
// long-press and double-press logic, across several register settings and
// idling patterns on both channels.
// ----------------------------------------------------------------------------
module tb_button_debounce_press_events_core;

  localparam int unsigned CycleLimit = 400000;

  // Expected-word store with its own copy of the debounce state.
  class press_scoreboard;
    logic                         act_lvl;
    logic [dbn_pkg::TimeW-1:0]    long_ms;
    logic [dbn_pkg::TimeW-1:0]    win_ms;
    logic                         dbl_en;
    logic [dbn_pkg::HistBits-1:0] hist;
    logic                         was_down;
    logic                         long_seen;
    logic [dbn_pkg::TimeW-1:0]    press_t0;
    logic [dbn_pkg::TimeW-1:0]    first_t;
    logic [dbn_pkg::PhaseW-1:0]   phase;
    dbn_pkg::result_t             word_q[$];
    string                        field_name[8];
    int unsigned n_samples, n_words, n_press, n_release, n_long, n_double;

    function new();
      field_name = '{"press_event", "release_event", "held_down", "held_up",
                     "down_changed", "long_start", "long_end", "double_press"};
      act_lvl   = dbn_pkg::RstActiveLevel;
      long_ms   = dbn_pkg::RstLongPressMs;
      win_ms    = dbn_pkg::RstDoubleWinMs;
      dbl_en    = dbn_pkg::RstDoubleEn;
      hist      = '0;
      was_down  = 1'b0;
      long_seen = 1'b0;
      press_t0  = '0;
      first_t   = '0;
      phase     = dbn_pkg::PhIdle;
    endfunction

    // Register write; values are cut to the register width.
    function void set_reg(logic [dbn_pkg::CfgIdxW-1:0] idx,
                          logic [dbn_pkg::CfgDataW-1:0] d);
      case (idx)
        dbn_pkg::CfgActiveLevel: act_lvl = d[0];
        dbn_pkg::CfgLongPressMs: long_ms = d;
        dbn_pkg::CfgDoubleWinMs: win_ms = d;
        dbn_pkg::CfgDoubleEn: begin
          dbl_en = d[0];
          phase  = dbn_pkg::PhIdle;
        end
        default: ;
      endcase
    endfunction

    // Double-press machine; returns one when the second press lands in time.
    function logic advance_double(logic pr, logic rl, logic [dbn_pkg::TimeW-1:0] t);
      logic [dbn_pkg::TimeW-1:0] since;
      logic hit;
      since = t - first_t;
      hit = 1'b0;
      case (phase)
        dbn_pkg::PhIdle: begin
          if (pr) begin
            phase   = dbn_pkg::PhFirst;
            first_t = t;
          end
        end
        dbn_pkg::PhFirst: begin
          if (rl) phase = dbn_pkg::PhAwait;
        end
        dbn_pkg::PhAwait: begin
          if (pr) begin
            if (since < win_ms) begin
              phase = dbn_pkg::PhDetected;
              hit   = 1'b1;
            end else begin
              phase   = dbn_pkg::PhFirst;
              first_t = t;
            end
          end else if (since >= win_ms) begin
            phase = dbn_pkg::PhIdle;
          end
        end
        dbn_pkg::PhDetected: begin
          if (rl) phase = dbn_pkg::PhCooldown;
        end
        dbn_pkg::PhCooldown: begin
          if (since >= dbn_pkg::CooldownMs) phase = dbn_pkg::PhIdle;
        end
        default: phase = dbn_pkg::PhIdle;
      endcase
      return hit;
    endfunction

    // Works out the result word of one accepted sample and queues it.
    function void note_sample(logic pin, logic [dbn_pkg::TimeW-1:0] t);
      dbn_pkg::result_t r;
      logic             down_after_shift;
      r    = '0;
      hist = {hist[dbn_pkg::HistBits-2:0], pin == act_lvl};
      down_after_shift = (hist == dbn_pkg::HistAll);
      if ((hist & dbn_pkg::PatMask) == dbn_pkg::PatPress) begin
        r.press_event = 1'b1;
        hist = dbn_pkg::HistAll;
      end
      if ((hist & dbn_pkg::PatMask) == dbn_pkg::PatRelease) begin
        r.release_event = 1'b1;
        hist = '0;
      end
      if (dbl_en) r.double_press = advance_double(r.press_event, r.release_event, t);
      r.held_down = (hist == dbn_pkg::HistAll);
      r.held_up   = (hist == '0);
      // Long-press timing runs on the final down status.
      if (r.held_down) begin
        if (!was_down) begin
          was_down  = 1'b1;
          press_t0  = t;
          long_seen = 1'b0;
        end else if (!long_seen && (t - press_t0) >= long_ms) begin
          long_seen    = 1'b1;
          r.long_start = 1'b1;
        end
      end else if (was_down) begin
        was_down   = 1'b0;
        r.long_end = long_seen;
      end
      r.down_changed = (r.held_down != down_after_shift);
      n_samples++;
      n_press   += r.press_event;
      n_release += r.release_event;
      n_long    += r.long_start;
      n_double  += r.double_press;
      word_q.push_back(r);
    endfunction

    // Compares a received word with the oldest expectation, field by field.
    function bit check_word(dbn_pkg::result_t got, output string msg);
      dbn_pkg::result_t want;
      msg = "";
      n_words++;
      if (word_q.size() == 0) begin
        msg = $sformatf("word %0d arrived with no sample pending", n_words);
        return 1'b0;
      end
      want = word_q.pop_front();
      for (int i = 0; i < 8; i++) begin
        if (got[7-i] !== want[7-i]) begin
          msg = {msg, $sformatf(" %s=%b (want %b)", field_name[i], got[7-i], want[7-i])};
        end
      end
      if (msg != "") begin
        msg = $sformatf("word %0d:%s", n_words, msg);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function int pending();
      return word_q.size();
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic                         cfg_we_i;
  logic [dbn_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [dbn_pkg::CfgDataW-1:0] cfg_data_i;

  dbn_in_if  in_if ();
  dbn_out_if out_if ();

  button_debounce_press_events_core dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_s      (in_if),
    .out_s     (out_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  press_scoreboard sb = new();

  int unsigned errors;
  int unsigned cycle_cnt;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned hold_left;
  int unsigned n_settings;
  logic [dbn_pkg::TimeW-1:0] now_t;

  always #4 clk_i = ~clk_i;

  // Every mismatch gives one line and one count.
  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Run-length guard.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_cnt, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: check each accepted word, then choose the next ready.
  always @(posedge clk_i) begin
    string            msg;
    dbn_pkg::result_t got;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = {out_if.press_event, out_if.release_event, out_if.held_down, out_if.held_up,
               out_if.down_changed, out_if.long_start, out_if.long_end, out_if.double_press};
        if (!sb.check_word(got, msg)) report_mismatch(msg);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Offers one sample, idling first at the chosen rate, and waits for it to go.
  task automatic send_word(input logic pin, input logic [dbn_pkg::TimeW-1:0] t);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.pin_level <= pin;
    in_if.now_ms    <= t;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_sample(pin, t);
  endtask

  // Waits until every expected word is back, then lets the core settle.
  task automatic wait_drained();
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [dbn_pkg::CfgIdxW-1:0] idx,
                           input logic [dbn_pkg::CfgDataW-1:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    sb.set_reg(idx, d);
  endtask

  task automatic apply_config(input logic [dbn_pkg::CfgDataW-1:0] act_d,
                              input logic [dbn_pkg::CfgDataW-1:0] long_d,
                              input logic [dbn_pkg::CfgDataW-1:0] win_d, input bit wr_en,
                              input logic [dbn_pkg::CfgDataW-1:0] en_d);
    write_reg(dbn_pkg::CfgActiveLevel, act_d);
    write_reg(dbn_pkg::CfgLongPressMs, long_d);
    write_reg(dbn_pkg::CfgDoubleWinMs, win_d);
    if (wr_en) write_reg(dbn_pkg::CfgDoubleEn, en_d);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    n_settings++;
  endtask

  // Mostly steady runs long enough to debounce, with bounces and glitches.
  task automatic run_samples(input int unsigned n, input int unsigned step_max,
                             input int unsigned pause_at);
    int unsigned sent;
    int unsigned run_len;
    int unsigned pick;
    logic        lvl;
    logic        pin;
    sent = 0;
    lvl  = 1'($urandom_range(1));
    while (sent < n) begin
      if ($urandom_range(99) < 80) run_len = $urandom_range(6, 24);
      else run_len = $urandom_range(1, 3);
      for (int unsigned k = 0; k < run_len && sent < n; k++) begin
        pin  = ($urandom_range(99) < 3) ? ~lvl : lvl;
        pick = $urandom_range(99);
        if (pick < 2) now_t = $urandom;
        else if (pick < 7) now_t = now_t + $urandom_range(2000);
        else now_t = now_t + $urandom_range(step_max);
        send_word(pin, now_t);
        sent++;
        // The sender stops here until every word has come back.
        if (sent == pause_at) begin
          in_if.valid <= 1'b0;
          do @(posedge clk_i); while (sb.pending() != 0);
        end
      end
      lvl = ~lvl;
    end
    in_if.valid <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned mode,
                           input logic [dbn_pkg::CfgDataW-1:0] act_d,
                           input logic [dbn_pkg::CfgDataW-1:0] long_d,
                           input logic [dbn_pkg::CfgDataW-1:0] win_d,
                           input bit wr_en, input logic [dbn_pkg::CfgDataW-1:0] en_d,
                           input logic [dbn_pkg::TimeW-1:0] start_t, input int unsigned hold,
                           input int unsigned pause_at);
    wait_drained();
    apply_config(act_d, long_d, win_d, wr_en, en_d);
    case (mode)
      1: begin src_idle_pct = 50; snk_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  snk_stall_pct = 50; end
      3: begin src_idle_pct = 8;  snk_stall_pct = 8;  end
      default: begin src_idle_pct = 0; snk_stall_pct = 0; end
    endcase
    now_t = start_t;
    if (hold > 0) hold_left = hold;
    run_samples(150, 20, pause_at);
  endtask

  initial begin
    cfg_we_i        = 1'b0;
    cfg_idx_i       = '0;
    cfg_data_i      = '0;
    in_if.valid     = 1'b0;
    in_if.pin_level = 1'b0;
    in_if.now_ms    = '0;
    out_if.ready    = 1'b0;
    errors          = 0;
    cycle_cnt       = 0;
    hold_left       = 0;
    n_settings      = 0;
    src_idle_pct    = 0;
    snk_stall_pct   = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a few samples under the reset settings, timestamps at both ends.
    send_word(1'b1, 32'h0000_0000);
    send_word(1'b0, 32'hFFFF_FFFF);
    send_word(1'b1, 32'd5);
    in_if.valid <= 1'b0;
    wait_drained();
    // Zero long-press time, widest window, enable written with spare bits set.
    apply_config(32'd1, 32'd0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    // Press, then long press start on a wrapped timestamp.
    for (int i = 0; i < 6; i++) send_word(1'b1, 32'd100 + i);
    send_word(1'b1, 32'hFFFF_FFFF);
    // Release ends the long press; the flag stays until the next press.
    for (int i = 0; i < 6; i++) send_word(1'b0, i);
    // Second press inside the window gives a double press.
    for (int i = 0; i < 6; i++) send_word(1'b1, 32'd6 + i);
    in_if.valid <= 1'b0;

    // Random phases over several settings and idling patterns.
    run_phase(0, 32'hFFFF_FFFE, 32'd50, 32'd300, 1'b1, 32'd1, $urandom, 0, 0);
    run_phase(1, 32'd1, 32'hFFFF_FFFF, 32'd0, 1'b1, 32'd1, 32'hFFFF_FF00, 0, 0);
    run_phase(2, 32'd0, $urandom_range(150), $urandom_range(100, 400), 1'b0, 32'd0,
              $urandom, 300, 0);
    run_phase(3, 32'd1, dbn_pkg::RstLongPressMs, dbn_pkg::RstDoubleWinMs, 1'b1, 32'd0,
              $urandom, 0, 0);
    run_phase(0, 32'd1, 32'd0, 32'd200, 1'b1, 32'd1, $urandom, 0, 70);
    run_phase(1, 32'd0, 32'd20, 32'hFFFF_FFFF, 1'b1, 32'd1, $urandom, 0, 0);
    run_phase(2, 32'd1, $urandom_range(300), $urandom_range(400), 1'b1, 32'd1,
              $urandom, 0, 0);
    run_phase(3, 32'd0, $urandom_range(200), 32'd250, 1'b1, 32'd3, $urandom, 0, 0);

    // Drain, then keep clocking to catch any stray word.
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (8) @(posedge clk_i);

    $display("Ran %0d samples and %0d result words over %0d register settings",
             sb.n_samples, sb.n_words, n_settings);
    $display("and four idling patterns; events seen: %0d presses, %0d releases, %0d long %s",
             sb.n_press, sb.n_release, sb.n_long,
             $sformatf("presses, %0d double presses.", sb.n_double));
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
src/dbn_pkg.sv
src/dbn_if.sv
src/dbn_hist.sv
src/dbn_long.sv
src/dbn_dbl.sv
src/dbn_outq.sv
src/button_debounce_press_events_core.sv
tb/tb_button_debounce_press_events_core.sv
